// File: src/dpwp_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel to world point: shared definitions
// Image geometry, field widths, stream packing, register codes and fixed-point
// constants used by the depth pixel back-projection pipeline.
// ----------------------------------------------------------------------------
package dpwp_pkg;

  // Image geometry and sampling grid.
  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;
  localparam int PIXEL_SKIP   = 2;

  // Field widths.
  localparam int COL_W    = 10;
  localparam int ROW_W    = 9;
  localparam int RAW_W    = 16;
  localparam int PIDX_W   = 4;
  localparam int WORD_W   = 32;
  localparam int CENTER_W = 16;
  localparam int MARGIN_W = 8;

  // Input tdata packing, lowest bits first.
  localparam int ROW_LSB     = COL_W;
  localparam int RAW_LSB     = ROW_LSB + ROW_W;
  localparam int PIDX_LSB    = RAW_LSB + RAW_W;
  localparam int PVAL_LSB    = PIDX_LSB + PIDX_W;
  localparam int IN_FIELDS_W = PVAL_LSB + WORD_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 3 * WORD_W;

  // Pose storage: nine rotation words row-major, then the position.
  localparam int POSE_WORDS    = 12;
  localparam int POSE_POS_BASE = 9;

  // Configuration registers.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X_INV = 3'd0,
    CFG_FOCAL_Y_INV = 3'd1,
    CFG_CENTER_X    = 3'd2,
    CFG_CENTER_Y    = 3'd3,
    CFG_DEPTH_GAIN  = 3'd4,
    CFG_DEPTH_MIN   = 3'd5,
    CFG_DEPTH_MAX   = 3'd6,
    CFG_EDGE_MARGIN = 3'd7
  } cfg_idx_e;

  localparam logic [WORD_W-1:0] DEPTH_MAX_RESET = 32'd327680;

  // Grid test widths: margin bounds and the remainder by PIXEL_SKIP.
  localparam int DIM_MAX  = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int DIM_W    = $clog2(DIM_MAX + 1);
  localparam int GRID_W   = (DIM_W > COL_W + 1) ? DIM_W : COL_W + 1;
  localparam int OFF_W    = COL_W;
  localparam int SKIP_W   = $clog2(PIXEL_SKIP + 1);
  // Reciprocal with enough guard bits to give the exact quotient for any offset.
  localparam int SKIP_SH  = OFF_W + 5;
  localparam int RECIP_W  = SKIP_SH + 1;
  localparam logic [RECIP_W-1:0] SKIP_RECIP =
    RECIP_W'(((1 << SKIP_SH) + PIXEL_SKIP - 1) / PIXEL_SKIP);
  localparam logic [SKIP_W-1:0]  SKIP_VAL   = SKIP_W'(PIXEL_SKIP);

  // Fixed-point datapath widths.
  localparam int CENTER_FRAC = 4;
  localparam int DIFF_W      = CENTER_W + 1;
  localparam int DGAIN_W     = RAW_W + WORD_W;
  localparam int DGAIN_SH    = 8;
  localparam int DSUM_W      = DGAIN_W - DGAIN_SH + 1;
  localparam int MD_W        = CENTER_W + WORD_W;
  localparam int PROJ_LO_W   = 16;
  localparam int PH_W        = 2 * WORD_W;
  localparam int PL_W        = PROJ_LO_W + WORD_W;
  localparam int PROJ_SH     = 20;
  localparam int PR_W        = PH_W - PROJ_SH;
  localparam int ROT_SH      = 16;
  localparam int ROT_W       = PH_W - ROT_SH;
  localparam int ACC_W       = ROT_W + 2;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

// File: src/depth_pixel_to_world_point.sv
// ----------------------------------------------------------------------------
// Depth pixel to world point
// Seven-stage pipeline that filters raster depth pixels, scales them to metres
// and back-projects them through the pinhole model and the camera pose.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per transaction. tuser is the kind:
//   0 for a depth pixel, 1 for a pose word write. A pixel that lies outside
//   the edge margin or off the skip grid produces no result; a kept pixel
//   produces one master transaction with its world coordinates.
//   Pose words travel down the pipeline in order with the pixels, so a pose
//   write affects exactly the pixels accepted after it.
//   Throughput is one item per clock while the receiver accepts. A result is
//   presented on m_axis_tvalid_o from the output register; the arithmetic is
//   spread over the stages (depth gain, grid quotient, depth times offset, focal
//   reciprocal partials, rotation products, final sum).
//   When the receiver stalls, the result waits in the output register while
//   bubbles ahead of it keep filling; s_axis_tready_o drops only once every
//   stage holds an item.
//   Reset clears the pipeline, the pose to all zero and the registers to their
//   defaults (maximum depth 5.0 m). The user must write registers on the plain
//   write port only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point import dpwp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [WORD_W-1:0]      cfg_wdata_i,
  // Slave stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata from bit 0: pixel_column, pixel_row, depth_raw, pose_index, pose_value.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser from bit 0: func.
  input  logic [0:0]             s_axis_tuser_i,
  // Master stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata from bit 0: world_x, world_y, world_z.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // Configuration registers.
  logic [WORD_W-1:0]   fx_inv_q, fy_inv_q, gain_q, dmin_q, dmax_q;
  logic [CENTER_W-1:0] cx_q, cy_q;
  logic [MARGIN_W-1:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_inv_q <= '0;
      fy_inv_q <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      gain_q   <= '0;
      dmin_q   <= '0;
      dmax_q   <= DEPTH_MAX_RESET;
      margin_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FOCAL_X_INV: fx_inv_q <= cfg_wdata_i;
        CFG_FOCAL_Y_INV: fy_inv_q <= cfg_wdata_i;
        CFG_CENTER_X:    cx_q     <= cfg_wdata_i[CENTER_W-1:0];
        CFG_CENTER_Y:    cy_q     <= cfg_wdata_i[CENTER_W-1:0];
        CFG_DEPTH_GAIN:  gain_q   <= cfg_wdata_i;
        CFG_DEPTH_MIN:   dmin_q   <= cfg_wdata_i;
        CFG_DEPTH_MAX:   dmax_q   <= cfg_wdata_i;
        CFG_EDGE_MARGIN: margin_q <= cfg_wdata_i[MARGIN_W-1:0];
      endcase
    end
  end

  // Saturating projection: floor(mag * depth * inv / 2^36) with the sign applied.
  function automatic logic [WORD_W-1:0] proj_sat(input logic neg,
                                                 input logic [PH_W-1:0] ph,
                                                 input logic [PL_W-1:0] pl);
    logic [PH_W-1:0]   sum;
    logic [PR_W-1:0]   r;
    logic [WORD_W-1:0] res;
    sum = ph + PH_W'(pl[PL_W-1:PROJ_LO_W]);
    r   = sum[PH_W-1:PROJ_SH];
    if (!neg) begin
      res = (|r[PR_W-1:WORD_W-1]) ? SAT_MAX : r[WORD_W-1:0];
    end else begin
      res = ((|r[PR_W-1:WORD_W]) || (r[WORD_W-1] && (|r[WORD_W-2:0]))) ?
            SAT_MIN : WORD_W'(0) - r[WORD_W-1:0];
    end
    return res;
  endfunction

  // Input fields.
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [RAW_W-1:0]  in_raw;
  logic [PIDX_W-1:0] in_pidx;
  logic [WORD_W-1:0] in_pval;

  assign in_col  = s_axis_tdata_i[ROW_LSB-1:0];
  assign in_row  = s_axis_tdata_i[RAW_LSB-1:ROW_LSB];
  assign in_raw  = s_axis_tdata_i[PIDX_LSB-1:RAW_LSB];
  assign in_pidx = s_axis_tdata_i[PVAL_LSB-1:PIDX_LSB];
  assign in_pval = s_axis_tdata_i[IN_FIELDS_W-1:PVAL_LSB];

  // Stage advance chain: a stage loads when it is empty or its successor loads.
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, out_v_q;

  assign adv7 = !out_v_q || m_axis_tready_i;
  assign adv6 = !v6_q || adv7;
  assign adv5 = !v5_q || adv6;
  assign adv4 = !v4_q || adv5;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign s_axis_tready_o = adv1;
  assign m_axis_tvalid_o = out_v_q;

  // Pose item tags travelling with the data.
  logic              pose1_q, pose2_q, pose3_q, pose4_q, pose5_q;
  logic [PIDX_W-1:0] pidx1_q, pidx2_q, pidx3_q, pidx4_q, pidx5_q;
  logic [WORD_W-1:0] pval1_q, pval2_q, pval3_q, pval4_q, pval5_q;

  // ---------------- Stage 1: depth gain, center offsets, margin test ----------
  logic [DIFF_W-1:0]   diffx, diffy, ndiffx, ndiffy;
  logic [GRID_W-1:0]   gcol, grow, gmar;
  logic                inx_d, iny_d;
  logic [DGAIN_W-1:0]  dgain1_q;
  logic                negx1_q, negy1_q, inx1_q, iny1_q;
  logic [CENTER_W-1:0] magx1_q, magy1_q;
  logic [OFF_W-1:0]    offx1_q, offy1_q;

  always_comb begin
    diffx  = DIFF_W'({in_col, {CENTER_FRAC{1'b0}}}) - DIFF_W'(cx_q);
    diffy  = DIFF_W'({in_row, {CENTER_FRAC{1'b0}}}) - DIFF_W'(cy_q);
    ndiffx = DIFF_W'(0) - diffx;
    ndiffy = DIFF_W'(0) - diffy;
    gcol   = GRID_W'(in_col);
    grow   = GRID_W'(in_row);
    gmar   = GRID_W'(margin_q);
    inx_d  = (gcol >= gmar) && (gcol + gmar < GRID_W'(IMAGE_WIDTH));
    iny_d  = (grow >= gmar) && (grow + gmar < GRID_W'(IMAGE_HEIGHT));
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      pose1_q  <= s_axis_tuser_i[0];
      pidx1_q  <= in_pidx;
      pval1_q  <= in_pval;
      dgain1_q <= DGAIN_W'(in_raw) * DGAIN_W'(gain_q);
      negx1_q  <= diffx[DIFF_W-1];
      negy1_q  <= diffy[DIFF_W-1];
      magx1_q  <= diffx[DIFF_W-1] ? ndiffx[CENTER_W-1:0] : diffx[CENTER_W-1:0];
      magy1_q  <= diffy[DIFF_W-1] ? ndiffy[CENTER_W-1:0] : diffy[CENTER_W-1:0];
      inx1_q   <= inx_d;
      iny1_q   <= iny_d;
      offx1_q  <= in_col - OFF_W'(margin_q);
      offy1_q  <= OFF_W'(in_row) - OFF_W'(margin_q);
    end
  end

  // ---------------- Stage 2: depth offset and clamp, grid quotient -----------
  logic [DSUM_W-1:0]        dsum;
  logic [OFF_W+RECIP_W-1:0] qprodx, qprody;
  logic [WORD_W-1:0]        depth2_q;
  logic                     negx2_q, negy2_q, inx2_q, iny2_q;
  logic [CENTER_W-1:0]      magx2_q, magy2_q;
  logic [OFF_W-1:0]         offx2_q, offy2_q, qx2_q, qy2_q;

  // The offset is added to a non-negative product, so the depth can never
  // fall below the minimum; only the clamp at the maximum remains.
  always_comb begin
    dsum   = DSUM_W'(dgain1_q[DGAIN_W-1:DGAIN_SH]) + DSUM_W'(dmin_q);
    qprodx = {{RECIP_W{1'b0}}, offx1_q} * {{OFF_W{1'b0}}, SKIP_RECIP};
    qprody = {{RECIP_W{1'b0}}, offy1_q} * {{OFF_W{1'b0}}, SKIP_RECIP};
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      pose2_q  <= pose1_q;
      pidx2_q  <= pidx1_q;
      pval2_q  <= pval1_q;
      depth2_q <= (dsum > DSUM_W'(dmax_q)) ? dmax_q : dsum[WORD_W-1:0];
      negx2_q  <= negx1_q;
      negy2_q  <= negy1_q;
      magx2_q  <= magx1_q;
      magy2_q  <= magy1_q;
      inx2_q   <= inx1_q;
      iny2_q   <= iny1_q;
      offx2_q  <= offx1_q;
      offy2_q  <= offy1_q;
      qx2_q    <= qprodx[SKIP_SH +: OFF_W];
      qy2_q    <= qprody[SKIP_SH +: OFF_W];
    end
  end

  // ---------------- Stage 3: grid decision, offset times depth ---------------
  logic [OFF_W+SKIP_W-1:0] qkx, qky;
  logic                    grid_ok;
  logic [MD_W-1:0]         mdx3_q, mdy3_q;
  logic [WORD_W-1:0]       depth3_q;
  logic                    negx3_q, negy3_q;

  always_comb begin
    qkx     = {{SKIP_W{1'b0}}, qx2_q} * {{OFF_W{1'b0}}, SKIP_VAL};
    qky     = {{SKIP_W{1'b0}}, qy2_q} * {{OFF_W{1'b0}}, SKIP_VAL};
    grid_ok = inx2_q && iny2_q &&
              (qkx == {{SKIP_W{1'b0}}, offx2_q}) && (qky == {{SKIP_W{1'b0}}, offy2_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      pose3_q  <= pose2_q;
      pidx3_q  <= pidx2_q;
      pval3_q  <= pval2_q;
      mdx3_q   <= MD_W'(magx2_q) * MD_W'(depth2_q);
      mdy3_q   <= MD_W'(magy2_q) * MD_W'(depth2_q);
      depth3_q <= depth2_q;
      negx3_q  <= negx2_q;
      negy3_q  <= negy2_q;
    end
  end

  // ---------------- Stage 4: focal reciprocal partial products --------------
  logic [PH_W-1:0]   phx4_q, phy4_q;
  logic [PL_W-1:0]   plx4_q, ply4_q;
  logic [WORD_W-1:0] depth4_q;
  logic              negx4_q, negy4_q;

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      pose4_q  <= pose3_q;
      pidx4_q  <= pidx3_q;
      pval4_q  <= pval3_q;
      phx4_q   <= PH_W'(mdx3_q[MD_W-1:PROJ_LO_W]) * PH_W'(fx_inv_q);
      phy4_q   <= PH_W'(mdy3_q[MD_W-1:PROJ_LO_W]) * PH_W'(fy_inv_q);
      plx4_q   <= PL_W'(mdx3_q[PROJ_LO_W-1:0]) * PL_W'(fx_inv_q);
      ply4_q   <= PL_W'(mdy3_q[PROJ_LO_W-1:0]) * PL_W'(fy_inv_q);
      depth4_q <= depth3_q;
      negx4_q  <= negx3_q;
      negy4_q  <= negy3_q;
    end
  end

  // ---------------- Stage 5: camera point with saturation --------------------
  logic signed [WORD_W-1:0] cam5_q [3];

  always_ff @(posedge clk_i) begin
    if (adv5) begin
      pose5_q   <= pose4_q;
      pidx5_q   <= pidx4_q;
      pval5_q   <= pval4_q;
      cam5_q[0] <= proj_sat(negx4_q, phx4_q, plx4_q);
      cam5_q[1] <= proj_sat(negy4_q, phy4_q, ply4_q);
      cam5_q[2] <= depth4_q[WORD_W-1] ? SAT_MAX : depth4_q;
    end
  end

  // ---------------- Pose store --------------------------------------------
  // A pose word is written as it leaves stage 5, the point where pixels read
  // the pose, which keeps pose writes ordered with the pixel stream.
  logic [POSE_WORDS-1:0][WORD_W-1:0] pose_q;
  logic                              pose_we;

  assign pose_we = v5_q && pose5_q && adv6 && (pidx5_q < PIDX_W'(POSE_WORDS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_q <= '0;
    end else if (pose_we) begin
      pose_q[pidx5_q] <= pval5_q;
    end
  end

  // ---------------- Stage 6: rotation products ------------------------------
  logic signed [PH_W-1:0]   rot_full [3][3];
  logic signed [ROT_W-1:0]  prod6_q  [3][3];
  logic signed [WORD_W-1:0] pos6_q   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_full[i][j] = $signed(pose_q[3*i+j]) * cam5_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv6) begin
      for (int i = 0; i < 3; i++) begin
        pos6_q[i] <= $signed(pose_q[POSE_POS_BASE+i]);
        for (int j = 0; j < 3; j++) begin
          // Arithmetic shift floors the Q32.32 product to Q32.16.
          prod6_q[i][j] <= rot_full[i][j][PH_W-1:ROT_SH];
        end
      end
    end
  end

  // ---------------- Stage 7: translation, saturation, output register -------
  logic signed [ACC_W-1:0]  acc  [3];
  logic        [WORD_W-1:0] wsat [3];
  logic [OUT_TDATA_W-1:0]   out_data_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(pos6_q[i]) + ACC_W'(prod6_q[i][0]) + ACC_W'(prod6_q[i][1]) +
               ACC_W'(prod6_q[i][2]);
      if (acc[i][ACC_W-1] && !(&acc[i][ACC_W-2:WORD_W-1])) begin
        wsat[i] = SAT_MIN;
      end else if (!acc[i][ACC_W-1] && (|acc[i][ACC_W-2:WORD_W-1])) begin
        wsat[i] = SAT_MAX;
      end else begin
        wsat[i] = acc[i][WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv7) begin
      out_data_q <= {wsat[2], wsat[1], wsat[0]};
    end
  end

  assign m_axis_tdata_o = out_data_q;

  // ---------------- Valid bits --------------------------------------------
  // Dropped pixels leave at stage 3; pose items leave after their write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q && (pose2_q || grid_ok);
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
      if (adv6) v6_q <= v5_q && !pose5_q;
      if (adv7) out_v_q <= v6_q;
    end
  end

  // ---------------- Assertions --------------------------------------------
  // The input side only backs up when every stage is full behind a stalled output.
  a_ready_only_on_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while the pipeline has room");

  // A pose item never reaches the rotation stage.
  a_pose_leaves_pipeline : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && pose5_q && adv6) |=> !v6_q)
    else $error("pose transaction passed into the rotation stage");

  // The pose changes only when a pose item leaves stage 5.
  a_pose_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v5_q && pose5_q && adv6) |=> $stable(pose_q))
    else $error("pose words changed without a pose write");

endmodule

// File: test/depth_pixel_to_world_point_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth pixel to world point testbench
// Drives depth pixels and pose words on the slave stream with random gaps and
// receiver stalls. A behavioral model of the grid filter, depth scaling,
// pinhole back-projection and pose transform predicts every world point, and
// each master transaction is compared with the oldest prediction. Registers
// change only while the pipeline is empty.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_tb;
  import dpwp_pkg::*;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_POSE  = 1'b1;

  localparam int ROT_XX     = 0;
  localparam int ROT_YY     = 4;
  localparam int ROT_ZZ     = 8;
  localparam int POS_X      = POSE_POS_BASE;
  localparam int POS_Y      = POSE_POS_BASE + 1;
  localparam int POS_Z      = POSE_POS_BASE + 2;
  localparam int POSE_SPARE = POSE_WORDS;
  localparam int POSE_TOP   = (1 << PIDX_W) - 1;

  localparam int SET_MAX    = 0;
  localparam int SET_ZERO   = 1;
  localparam int SET_RANDOM = 2;

  localparam int PIPE_LATENCY    = 6;
  localparam int MAX_GAP         = 18;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 106;

  typedef struct packed {
    logic                func;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    prow;
    logic [RAW_W-1:0]    raw;
    logic [PIDX_W-1:0]   pidx;
    logic [WORD_W-1:0]   pval;
  } sensor_item_t;

  // Element 0 is world x, matching the tdata layout.
  typedef logic [2:0][WORD_W-1:0] world_point_t;

  typedef enum {ROW_CFG, ROW_PREDICT, ROW_TYPED, ROW_DROP} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    sensor_item_t      item;
    cfg_idx_e          reg_idx;
    logic [WORD_W-1:0] reg_val;
    world_point_t      point;
  } stim_row_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  cfg_idx_e               cfg_idx   = CFG_FOCAL_X_INV;
  logic [WORD_W-1:0]      cfg_wdata = '0;
  logic                   s_valid   = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [0:0]             s_tuser   = '0;
  logic                   m_ready   = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Shadow of the registers and the pose held by the block.
  logic [WORD_W-1:0]        focal_x_inv_q, focal_y_inv_q, depth_gain_q;
  logic [WORD_W-1:0]        depth_min_q, depth_max_q;
  logic [CENTER_W-1:0]      center_x_q, center_y_q;
  logic [MARGIN_W-1:0]      edge_margin_q;
  logic signed [WORD_W-1:0] pose_q [POSE_WORDS];

  world_point_t pending_points [$];
  stim_row_t    directed_rows [$];
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;
  bit           fast_send      = 1'b0;
  bit           fast_recv      = 1'b0;

  always #1 clk_i = ~clk_i;

  depth_pixel_to_world_point dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  function automatic longint clamp_word(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < -longint'(64'h8000_0000)) return -longint'(64'h8000_0000);
    return v;
  endfunction

  function automatic bit on_grid(int unsigned p, int unsigned size);
    int unsigned m;
    m = edge_margin_q;
    if (p < m) return 1'b0;
    if (p + m >= size) return 1'b0;
    return ((p - m) % PIXEL_SKIP) == 0;
  endfunction

  // Offset from the principal point times depth times 1/f, truncated toward
  // zero. The product is split so that no term overflows 64 bits.
  function automatic longint camera_axis(int unsigned pix, int unsigned center,
                                         int unsigned depth, int unsigned inv);
    longint          diff, s;
    longint unsigned mag, hi, lo, r;
    diff = longint'(pix) * 16 - longint'(center);
    mag  = (diff < 0) ? -diff : diff;
    mag  = mag * depth;
    hi   = mag >> 16;
    lo   = mag & 64'hFFFF;
    r    = (hi * inv + ((lo * inv) >> 16)) >> 20;
    s    = r;
    return clamp_word((diff < 0) ? -s : s);
  endfunction

  // Applies one item to the shadow state; returns 1 with the point when the
  // item yields a world point.
  function automatic bit project_to_world(sensor_item_t it, output world_point_t pt);
    longint unsigned d;
    logic [WORD_W-1:0] depth;
    longint cam [3];
    longint acc, prod, dz, w;
    pt = '0;
    if (it.func == FUNC_POSE) begin
      if (it.pidx < POSE_WORDS) pose_q[it.pidx] = it.pval;
      return 1'b0;
    end
    if (!on_grid(it.col, IMAGE_WIDTH) || !on_grid(it.prow, IMAGE_HEIGHT)) return 1'b0;
    d = it.raw;
    d = ((d * depth_gain_q) >> 8) + depth_min_q;
    if (d > depth_max_q) depth = depth_max_q;
    else if (d < depth_min_q) return 1'b0;
    else depth = d[WORD_W-1:0];
    dz = depth;
    cam[0] = camera_axis(it.col, center_x_q, depth, focal_x_inv_q);
    cam[1] = camera_axis(it.prow, center_y_q, depth, focal_y_inv_q);
    cam[2] = clamp_word(dz);
    for (int i = 0; i < 3; i++) begin
      acc = pose_q[POSE_POS_BASE + i];
      for (int j = 0; j < 3; j++) begin
        prod = pose_q[3 * i + j];
        prod = prod * cam[j];
        acc += prod >>> 16;
      end
      w = clamp_word(acc);
      pt[i] = w[WORD_W-1:0];
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t make_pixel(row_kind_e kind, int col, int prow, int raw,
                                           world_point_t pt = '0);
    stim_row_t r;
    r.kind      = kind;
    r.item      = '0;
    r.item.func = FUNC_PIXEL;
    r.item.col  = col;
    r.item.prow = prow;
    r.item.raw  = raw;
    r.reg_idx   = CFG_FOCAL_X_INV;
    r.reg_val   = '0;
    r.point     = pt;
    return r;
  endfunction

  function automatic stim_row_t make_pose(int idx, logic [WORD_W-1:0] val);
    stim_row_t r;
    r           = make_pixel(ROW_DROP, 0, 0, 0);
    r.item.func = FUNC_POSE;
    r.item.pidx = idx;
    r.item.pval = val;
    return r;
  endfunction

  function automatic stim_row_t make_cfg(cfg_idx_e idx, logic [WORD_W-1:0] val);
    stim_row_t r;
    r         = make_pixel(ROW_CFG, 0, 0, 0);
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_setting(cfg_idx_e idx, int mode);
    logic [WORD_W-1:0] full, lo, hi;
    int draw;
    full = '1;
    lo   = 0;
    hi   = '1;
    case (idx)
      CFG_FOCAL_X_INV, CFG_FOCAL_Y_INV: begin
        lo = 4294967;
        hi = 21474836;
      end
      CFG_CENTER_X: begin
        full = 16'hFFFF;
        hi   = 10240;
      end
      CFG_CENTER_Y: begin
        full = 16'hFFFF;
        hi   = 7680;
      end
      CFG_DEPTH_GAIN: begin
        lo = 1000;
        hi = 70000;
      end
      CFG_DEPTH_MIN: hi = 65536;
      CFG_DEPTH_MAX: begin
        lo = 65536;
        hi = 1048576;
      end
      CFG_EDGE_MARGIN: begin
        full = 8'hFF;
        hi   = 16;
      end
      default: ;
    endcase
    if (mode == SET_ZERO) return '0;
    // A full margin would drop every pixel, so the wide setting uses an odd
    // margin that shifts the grid instead.
    if (mode == SET_MAX) return (idx == CFG_EDGE_MARGIN) ? 1 : full;
    draw = $urandom_range(0, 7);
    if (draw == 0) return '0;
    if (draw == 1) return full;
    if (draw == 2) return $urandom & full;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [WORD_W-1:0] pick_pose_value(int idx);
    if ($urandom_range(0, 4) == 0) return $urandom;
    if (idx < POSE_POS_BASE) return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
    return $urandom_range(0, 200 * 65536) - 100 * 65536;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [WORD_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FOCAL_X_INV: focal_x_inv_q = val;
      CFG_FOCAL_Y_INV: focal_y_inv_q = val;
      CFG_CENTER_X:    center_x_q    = val[CENTER_W-1:0];
      CFG_CENTER_Y:    center_y_q    = val[CENTER_W-1:0];
      CFG_DEPTH_GAIN:  depth_gain_q  = val;
      CFG_DEPTH_MIN:   depth_min_q   = val;
      CFG_DEPTH_MAX:   depth_max_q   = val;
      CFG_EDGE_MARGIN: edge_margin_q = val[MARGIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Dropped pixels leave no trace in the queue, so wait out the pipeline too.
  task automatic drain_pipeline();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic send_item(sensor_item_t it, row_kind_e kind, world_point_t typed);
    logic [IN_TDATA_W-1:0] word;
    world_point_t pt;
    bit has_point;
    int gap;
    word = '0;
    word[COL_W-1:0]          = it.col;
    word[ROW_LSB +: ROW_W]   = it.prow;
    word[RAW_LSB +: RAW_W]   = it.raw;
    word[PIDX_LSB +: PIDX_W] = it.pidx;
    word[PVAL_LSB +: WORD_W] = it.pval;
    gap = fast_send ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= word;
    s_tuser <= it.func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    has_point = project_to_world(it, pt);
    if (kind == ROW_TYPED) pending_points.push_back(typed);
    else if (kind == ROW_PREDICT && has_point) pending_points.push_back(pt);
  endtask

  // Receiver: a random stall ahead of every result, none in quiet stretches.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = fast_recv ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_ready));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    world_point_t want, got;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = m_axis_tdata_o;
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected world point %h", got);
      end else begin
        want = pending_points.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got[i] !== want[i]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("world coordinate %0d mismatch: expected %h, got %h",
                       i, want[i], got[i]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sensor_item_t it;
    logic [WORD_W-1:0] val;
    int m;
    focal_x_inv_q = '0;
    focal_y_inv_q = '0;
    center_x_q    = '0;
    center_y_q    = '0;
    depth_gain_q  = '0;
    depth_min_q   = '0;
    depth_max_q   = DEPTH_MAX_RESET;
    edge_margin_q = '0;
    for (int i = 0; i < POSE_WORDS; i++) pose_q[i] = '0;

    // Register defaults: zero gain and focal terms put every kept pixel at the
    // camera origin, so the world point is the position words.
    directed_rows.push_back(make_pixel(ROW_TYPED, 0, 0, 0, '0));
    directed_rows.push_back(make_pixel(ROW_DROP, 1, 0, 0));
    directed_rows.push_back(make_pixel(ROW_DROP, 0, 1, 100));
    directed_rows.push_back(make_pixel(ROW_DROP, 1023, 0, 0));
    directed_rows.push_back(make_pixel(ROW_DROP, 0, 511, 65535));
    directed_rows.push_back(make_pose(POSE_TOP, 32'h7FFF_FFFF));
    directed_rows.push_back(make_pose(POSE_SPARE, 32'h8000_0000));
    directed_rows.push_back(make_pixel(ROW_TYPED, 638, 478, 65535, '0));
    directed_rows.push_back(make_pose(POS_X, 32'h8000_0000));
    directed_rows.push_back(make_pose(POS_Y, 32'h7FFF_FFFF));
    directed_rows.push_back(make_pose(POS_Z, 32'h0001_0000));
    directed_rows.push_back(make_pixel(ROW_TYPED, 2, 4, 1234,
                                       {32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000}));
    // A margin that leaves no row inside the image drops everything.
    directed_rows.push_back(make_cfg(CFG_EDGE_MARGIN, 255));
    directed_rows.push_back(make_pixel(ROW_DROP, 320, 240, 500));
    directed_rows.push_back(make_cfg(CFG_EDGE_MARGIN, 239));
    directed_rows.push_back(make_pixel(ROW_PREDICT, 239, 239, 500));
    directed_rows.push_back(make_pixel(ROW_DROP, 240, 239, 500));
    directed_rows.push_back(make_pixel(ROW_DROP, 239, 241, 500));
    directed_rows.push_back(make_cfg(CFG_FOCAL_X_INV, 8181081));
    directed_rows.push_back(make_cfg(CFG_FOCAL_Y_INV, 8181081));
    directed_rows.push_back(make_cfg(CFG_CENTER_X, 5120));
    directed_rows.push_back(make_cfg(CFG_CENTER_Y, 3840));
    directed_rows.push_back(make_cfg(CFG_DEPTH_GAIN, 16777));
    directed_rows.push_back(make_cfg(CFG_DEPTH_MIN, 16384));
    directed_rows.push_back(make_cfg(CFG_DEPTH_MAX, 327680));
    directed_rows.push_back(make_cfg(CFG_EDGE_MARGIN, 0));
    directed_rows.push_back(make_pose(ROT_XX, 32'h0001_0000));
    directed_rows.push_back(make_pose(ROT_YY, 32'h0001_0000));
    directed_rows.push_back(make_pose(ROT_ZZ, 32'h0001_0000));
    directed_rows.push_back(make_pixel(ROW_PREDICT, 0, 0, 0));
    directed_rows.push_back(make_pixel(ROW_PREDICT, 638, 478, 65535));
    directed_rows.push_back(make_pixel(ROW_PREDICT, 320, 240, 2000));
    // Maximum below minimum: every depth clamps to the maximum and is kept.
    directed_rows.push_back(make_cfg(CFG_DEPTH_MAX, 0));
    directed_rows.push_back(make_pixel(ROW_PREDICT, 100, 50, 3000));
    directed_rows.push_back(make_cfg(CFG_FOCAL_X_INV, 32'hFFFF_FFFF));
    directed_rows.push_back(make_cfg(CFG_DEPTH_GAIN, 32'hFFFF_FFFF));
    directed_rows.push_back(make_cfg(CFG_DEPTH_MAX, 32'hFFFF_FFFF));
    directed_rows.push_back(make_cfg(CFG_CENTER_X, 16'hFFFF));
    directed_rows.push_back(make_pixel(ROW_PREDICT, 0, 2, 65535));
    directed_rows.push_back(make_pixel(ROW_PREDICT, 638, 0, 65535));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_pipeline();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].kind, directed_rows[i].point);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      for (int r = 0; r <= CFG_EDGE_MARGIN; r++) begin
        val = pick_setting(cfg_idx_e'(r),
                           (phase == 0) ? SET_MAX : (phase == 1) ? SET_ZERO : SET_RANDOM);
        write_reg(cfg_idx_e'(r), val);
      end
      fast_send = ($urandom_range(0, 3) == 0);
      fast_recv = ($urandom_range(0, 3) == 0);

      // A complete pose first, then pixels with an occasional stray pose word.
      for (int k = 0; k < POSE_WORDS; k++) begin
        it      = {$urandom, $urandom, $urandom};
        it.func = FUNC_POSE;
        it.pidx = k;
        it.pval = pick_pose_value(k);
        send_item(it, ROW_PREDICT, '0);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) == 0) begin
          it.func = FUNC_POSE;
          it.pidx = $urandom_range(0, POSE_TOP);
          it.pval = pick_pose_value(it.pidx);
        end else begin
          it.func = FUNC_PIXEL;
          m = edge_margin_q;
          if ($urandom_range(0, 4) != 0 && m <= 239) begin
            it.col  = m + PIXEL_SKIP * $urandom_range(0, (IMAGE_WIDTH - 1 - 2 * m) / PIXEL_SKIP);
            it.prow = m + PIXEL_SKIP * $urandom_range(0, (IMAGE_HEIGHT - 1 - 2 * m) / PIXEL_SKIP);
          end
          case ($urandom_range(0, 7))
            0:       it.raw = '0;
            1:       it.raw = '1;
            default: ;
          endcase
        end
        send_item(it, ROW_PREDICT, '0);
      end
    end

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
